// File: hw/rtl/column_min_max_runs_delta_stats_macros.svh
// Assertion macros shared by the checker of the column statistics block.
// Depends on nothing; included by name where assertions are written.
`ifndef COLUMN_MIN_MAX_RUNS_DELTA_STATS_MACROS_SVH
`define COLUMN_MIN_MAX_RUNS_DELTA_STATS_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define CMMRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked during reset.
`define CMMRD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hw/rtl/cmmrd_pkg.sv
// Shared types, codes and helper functions of the column statistics block.
// No dependencies; imported by the top level, lane, tree and accumulator modules.
`timescale 1ns / 1ps

package cmmrd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ELEMENT_SIZE   = 2'd0;
    localparam logic [1:0] CFG_SIGNED_MODE    = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_DELTA = 2'd2;

    // Element size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // One lane's view of its element and the step from the element below it
    typedef struct packed {
        logic [63:0] elem;
        logic        vld;
        logic        ne;
        logic        dm;
    } t_lane;

    // Node of the min/max reduction tree
    typedef struct packed {
        logic        vld;
        logic [63:0] mn;
        logic [63:0] mx;
    } t_node;

    // Settings and framing that travel with a request
    typedef struct packed {
        logic        last;
        logic        sgn;
        logic [1:0]  size;
        logic [63:0] effd;
    } t_ctl;

    // Per-word summary handed from the tree to the accumulator
    typedef struct packed {
        t_ctl        ctl;
        logic        any;
        logic        two;
        logic [3:0]  inc;
        logic        dok;
        logic [63:0] first;
        logic [63:0] final_e;
    } t_side;

    function automatic logic [63:0] f_mask(input logic [1:0] size);
        logic [63:0] m;
        unique case (size)
            SIZE_8:  m = 64'h0000_0000_0000_00FF;
            SIZE_16: m = 64'h0000_0000_0000_FFFF;
            SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
            SIZE_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] f_extend(input logic [63:0] v, input logic [1:0] size,
                                             input logic sgn);
        logic [63:0] r;
        unique case (size)
            SIZE_8:  r = {{56{sgn & v[7]}}, v[7:0]};
            SIZE_16: r = {{48{sgn & v[15]}}, v[15:0]};
            SIZE_32: r = {{32{sgn & v[31]}}, v[31:0]};
            SIZE_64: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] f_extract(input logic [63:0] word, input logic [1:0] size,
                                              input logic sgn, input logic [2:0] idx);
        logic [63:0] sh;
        unique case (size)
            SIZE_8:  sh = word >> {idx, 3'b000};
            SIZE_16: sh = word >> {idx, 4'b0000};
            SIZE_32: sh = word >> {idx, 5'b00000};
            SIZE_64: sh = word >> {idx, 6'b000000};
        endcase
        return f_extend(sh, size, sgn);
    endfunction

    function automatic logic f_less(input logic [63:0] a, input logic [63:0] b,
                                    input logic sgn);
        return sgn ? ($signed(a) < $signed(b)) : (a < b);
    endfunction

    function automatic t_node f_combine(input t_node a, input t_node b, input logic sgn);
        t_node r;
        if (!a.vld) begin
            r = b;
        end else if (!b.vld) begin
            r = a;
        end else begin
            r.vld = 1'b1;
            r.mn  = f_less(b.mn, a.mn, sgn) ? b.mn : a.mn;
            r.mx  = f_less(a.mx, b.mx, sgn) ? b.mx : a.mx;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/column_min_max_runs_delta_stats.sv
// Column statistics: min, max, run count and constant-delta check per column.
// Path: a final word's result passes the lane register, the tree levels and the
// accumulator's result register. Throughput: one word per cycle unless stalled
// by a full result register; the accumulator merges a whole word a cycle.
// Reset (synchronous, low): empties the pipeline, clears the statistics and sets
// 64-bit signed elements with a delta of zero.
`timescale 1ns / 1ps

module column_min_max_runs_delta_stats
    import cmmrd_pkg::*;
#(
    parameter int LANES       = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_element_count,
    input  logic        i_last_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_min_value,
    output logic [63:0] o_max_value,
    output logic [31:0] o_run_count,
    output logic        o_run_count_saturated,
    output logic [63:0] o_delta_out
);

    logic [1:0]  r_element_size;
    logic        r_signed_mode;
    logic [63:0] r_expected_delta;

    logic        r_s0_vld;
    t_ctl        r_s0_ctl;
    t_ctl        n_s0_ctl;
    logic [3:0]  w_cap;
    logic [3:0]  w_cnt;
    logic [63:0] w_effd_m;
    logic        w_rdy0;
    logic        w_load;
    t_lane       w_lane [LANES];

    logic        w_tree_rdy;
    logic        w_tree_vld;
    t_side       w_tree_side;
    t_node       w_tree_node;
    logic        w_acc_rdy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_size   <= SIZE_64;
            r_signed_mode    <= 1'b1;
            r_expected_delta <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ELEMENT_SIZE:   r_element_size   <= i_cfg_wdata[1:0];
                CFG_SIGNED_MODE:    r_signed_mode    <= i_cfg_wdata[0];
                CFG_EXPECTED_DELTA: r_expected_delta <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the element count to the word capacity and the lane count
    always_comb begin
        w_cap = 4'd8 >> r_element_size;
        if (w_cap > 4'(LANES)) begin
            w_cap = 4'(LANES);
        end
        w_cnt             = (i_element_count > w_cap) ? w_cap : i_element_count;
        n_s0_ctl.last     = i_last_word;
        n_s0_ctl.sgn      = r_signed_mode;
        n_s0_ctl.size     = r_element_size;
        n_s0_ctl.effd     = f_extend(r_expected_delta, r_element_size, 1'b1);
        w_effd_m          = r_expected_delta & f_mask(r_element_size);
    end

    // Input handshake into the lane stage
    assign w_rdy0     = !r_s0_vld || w_tree_rdy;
    assign w_load     = i_in_valid && w_rdy0;
    assign o_in_stall = !(w_rdy0 && i_rst_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_rdy0) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s0_ctl <= n_s0_ctl;
        end
    end

    // Element lanes
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        cmmrd_lane #(
            .IDX (k)
        ) u_lane (
            .i_clk       (i_clk),
            .i_en        (w_load),
            .i_data_word (i_data_word),
            .i_size      (r_element_size),
            .i_sgn       (r_signed_mode),
            .i_effd_m    (w_effd_m),
            .i_count     (w_cnt),
            .o_lane      (w_lane[k])
        );
    end

    // Reduce the lanes
    cmmrd_tree #(
        .LANES (LANES)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s0_vld),
        .i_ctl   (r_s0_ctl),
        .i_lane  (w_lane),
        .o_rdy   (w_tree_rdy),
        .o_vld   (w_tree_vld),
        .o_side  (w_tree_side),
        .o_node  (w_tree_node),
        .i_rdy   (w_acc_rdy)
    );

    // Merge into the column statistics and hold the result
    cmmrd_accum #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_accum (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_vld                 (w_tree_vld),
        .i_side                (w_tree_side),
        .i_node                (w_tree_node),
        .o_rdy                 (w_acc_rdy),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_min_value           (o_min_value),
        .o_max_value           (o_max_value),
        .o_run_count           (o_run_count),
        .o_run_count_saturated (o_run_count_saturated),
        .o_delta_out           (o_delta_out)
    );

endmodule

// File: hw/rtl/cmmrd_lane.sv
// One element lane: unpacks its element and compares it with its neighbor.
// Depends on cmmrd_pkg.
`timescale 1ns / 1ps

module cmmrd_lane
    import cmmrd_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_data_word,
    input  logic [1:0]  i_size,
    input  logic        i_sgn,
    input  logic [63:0] i_effd_m,
    input  logic [3:0]  i_count,
    output t_lane       o_lane
);

    localparam logic [2:0] K = 3'(IDX);

    logic [63:0] w_cur;
    logic [63:0] w_prv;
    logic [63:0] w_mask;
    t_lane       n_lane;
    t_lane       r_lane;

    // Unpack this element and the one below it, compare the step
    always_comb begin
        w_mask      = f_mask(i_size);
        w_cur       = f_extract(i_data_word, i_size, i_sgn, K);
        w_prv       = f_extract(i_data_word, i_size, i_sgn, K - 3'd1);
        n_lane.elem = w_cur;
        n_lane.vld  = i_count > 4'(IDX);
        n_lane.ne   = |((w_cur ^ w_prv) & w_mask);
        n_lane.dm   = ((w_cur - w_prv) & w_mask) == i_effd_m;
    end

    // Hold the lane result for the reduction tree
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// File: hw/rtl/cmmrd_tree.sv
// Registered min/max reduction tree over the lanes plus per-word summary.
// Depends on cmmrd_pkg; fed by cmmrd_lane, feeds cmmrd_accum.
`timescale 1ns / 1ps

module cmmrd_tree
    import cmmrd_pkg::*;
#(
    parameter int LANES = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_ctl  i_ctl,
    input  t_lane i_lane [LANES],
    output logic  o_rdy,
    output logic  o_vld,
    output t_side o_side,
    output t_node o_node,
    input  logic  i_rdy
);

    localparam int D  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NP = 1 << D;

    logic [D:1]   r_vld;
    t_side        r_side [1:D];
    logic [D+1:1] w_rdy;
    logic [D:1]   w_vin;
    t_side        w_sin  [1:D];
    t_node        w_node [1:2*NP-1];
    t_node        r_node [1:NP-1];
    t_side        w_side0;

    // Summarize the word: steps, delta check, first and final element
    always_comb begin
        w_side0.ctl     = i_ctl;
        w_side0.any     = i_lane[0].vld;
        w_side0.two     = 1'b0;
        w_side0.inc     = 4'd0;
        w_side0.dok     = 1'b1;
        w_side0.first   = i_lane[0].elem;
        w_side0.final_e = i_lane[0].elem;
        for (int k = 1; k < LANES; k++) begin
            if (i_lane[k].vld) begin
                w_side0.two     = 1'b1;
                w_side0.inc     = w_side0.inc + {3'b000, i_lane[k].ne};
                w_side0.dok     = w_side0.dok & i_lane[k].dm;
                w_side0.final_e = i_lane[k].elem;
            end
        end
    end

    assign w_rdy[D+1] = i_rdy;

    // Pipeline stages: valid, summary and backpressure
    for (genvar s = 1; s <= D; s++) begin : g_stage
        if (s == 1) begin : g_head
            assign w_vin[s] = i_vld;
            assign w_sin[s] = w_side0;
        end else begin : g_body
            assign w_vin[s] = r_vld[s-1];
            assign w_sin[s] = r_side[s-1];
        end

        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_vin[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s]) begin
                r_side[s] <= w_sin[s];
            end
        end
    end

    // Tree leaves: lanes, padded with empty nodes
    for (genvar j = 0; j < NP; j++) begin : g_leaf
        if (j < LANES) begin : g_used
            assign w_node[NP+j] = '{vld: i_lane[j].vld, mn: i_lane[j].elem,
                                    mx: i_lane[j].elem};
        end else begin : g_pad
            assign w_node[NP+j] = '0;
        end
    end

    // Internal nodes, one register level per tree level
    for (genvar i = 1; i < NP; i++) begin : g_node
        localparam int STG = D - ($clog2(i + 1) - 1);

        always_ff @(posedge i_clk) begin
            if (w_rdy[STG]) begin
                r_node[i] <= f_combine(w_node[2*i], w_node[2*i+1], w_sin[STG].ctl.sgn);
            end
        end

        assign w_node[i] = r_node[i];
    end

    assign o_rdy  = w_rdy[1];
    assign o_vld  = r_vld[D];
    assign o_side = r_side[D];
    assign o_node = w_node[1];

endmodule

// File: hw/rtl/cmmrd_accum.sv
// Column accumulator: merges each word into the running statistics and
// holds the result register. Depends on cmmrd_pkg; fed by cmmrd_tree.
`timescale 1ns / 1ps

module cmmrd_accum
    import cmmrd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_side       i_side,
    input  t_node       i_node,
    output logic        o_rdy,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_min_value,
    output logic [63:0] o_max_value,
    output logic [31:0] o_run_count,
    output logic        o_run_count_saturated,
    output logic [63:0] o_delta_out
);

    localparam int RUN_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
    localparam int SUM_W = RUN_W + 1;
    localparam logic [RUN_W-1:0] RUN_CEIL = '1;

    logic [63:0]      r_min,  n_min;
    logic [63:0]      r_max,  n_max;
    logic [63:0]      r_prev, n_prev;
    logic [RUN_W-1:0] r_run,  n_run;
    logic             r_dok,  n_dok;
    logic             r_seen, n_seen;
    logic             r_two,  n_two;

    logic             r_out_vld;
    logic [63:0]      r_out_min;
    logic [63:0]      r_out_max;
    logic [31:0]      r_out_run;
    logic             r_out_sat;
    logic [63:0]      r_out_delta;

    logic [63:0]      w_mask;
    logic [63:0]      w_effm;
    logic             w_bne;
    logic             w_bdm;
    logic [SUM_W-1:0] w_sum;
    logic             w_take;
    logic             w_emit;

    // Stall only a final word while the result register is still full
    assign o_rdy  = !i_side.ctl.last || !r_out_vld || !i_out_stall;
    assign w_take = i_vld && o_rdy;
    assign w_emit = w_take && i_side.ctl.last;

    // Merge the word summary into the running statistics
    always_comb begin
        w_mask = f_mask(i_side.ctl.size);
        w_effm = i_side.ctl.effd & w_mask;
        w_bne  = |((i_side.first ^ r_prev) & w_mask);
        w_bdm  = ((i_side.first - r_prev) & w_mask) == w_effm;
        w_sum  = {1'b0, r_run};
        n_min  = r_min;
        n_max  = r_max;
        n_prev = r_prev;
        n_run  = r_run;
        n_dok  = r_dok;
        n_seen = r_seen;
        n_two  = r_two;
        if (i_side.any) begin
            n_prev = i_side.final_e;
            n_seen = 1'b1;
            if (!r_seen) begin
                n_min = i_node.mn;
                n_max = i_node.mx;
                w_sum = SUM_W'(1) + SUM_W'(i_side.inc);
                n_dok = r_dok & i_side.dok;
                n_two = i_side.two;
            end else begin
                n_min = f_less(i_node.mn, r_min, i_side.ctl.sgn) ? i_node.mn : r_min;
                n_max = f_less(r_max, i_node.mx, i_side.ctl.sgn) ? i_node.mx : r_max;
                w_sum = {1'b0, r_run} + SUM_W'(i_side.inc) + SUM_W'(w_bne);
                n_dok = r_dok & i_side.dok & w_bdm;
                n_two = 1'b1;
            end
            n_run = (w_sum >= {1'b0, RUN_CEIL}) ? RUN_CEIL : w_sum[RUN_W-1:0];
        end
    end

    // Advance the statistics; clear them after a final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_emit) begin
            r_min  <= '0;
            r_max  <= '0;
            r_prev <= '0;
            r_run  <= '0;
            r_dok  <= 1'b1;
            r_seen <= 1'b0;
            r_two  <= 1'b0;
        end else if (w_take) begin
            r_min  <= n_min;
            r_max  <= n_max;
            r_prev <= n_prev;
            r_run  <= n_run;
            r_dok  <= n_dok;
            r_seen <= n_seen;
            r_two  <= n_two;
        end
    end

    // Result valid: set on a final word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_min   <= n_min;
            r_out_max   <= n_max;
            r_out_run   <= 32'(n_run);
            r_out_sat   <= n_run == RUN_CEIL;
            r_out_delta <= (i_side.ctl.effd != '0 && n_two && n_dok) ? i_side.ctl.effd : '0;
        end
    end

    assign o_out_valid           = r_out_vld;
    assign o_min_value           = r_out_min;
    assign o_max_value           = r_out_max;
    assign o_run_count           = r_out_run;
    assign o_run_count_saturated = r_out_sat;
    assign o_delta_out           = r_out_delta;

endmodule

// File: hw/rtl/cmmrd_checker.sv
// Port-level checks for the column statistics block, bound to the top level.
// Depends on column_min_max_runs_delta_stats_macros.svh.
`timescale 1ns / 1ps
`include "column_min_max_runs_delta_stats_macros.svh"

module cmmrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_min_value,
    input logic [63:0] o_max_value,
    input logic [31:0] o_run_count,
    input logic        o_run_count_saturated,
    input logic [63:0] o_delta_out
);

    // Hold a stalled result
    `CMMRD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")

    // An empty column reports all zeros
    `CMMRD_ASSERT(a_empty_zero, i_clk, i_rst_n, o_out_valid && o_run_count == 32'd0 |-> o_min_value == 64'd0 && o_max_value == 64'd0 && o_delta_out == 64'd0 && !o_run_count_saturated, "empty column result not zero")

    // A saturated counter is never zero
    `CMMRD_ASSERT(a_sat_nonzero, i_clk, i_rst_n, o_out_valid && o_run_count_saturated |-> o_run_count != 32'd0, "saturated run count is zero")

    // Hold the payload of a stalled result
    `CMMRD_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_min_value) && $stable(o_max_value) && $stable(o_run_count) && $stable(o_run_count_saturated) && $stable(o_delta_out), "stalled result changed")

    // Drop any result on reset
    `CMMRD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind column_min_max_runs_delta_stats cmmrd_checker u_checker (.*);
